/* hw/rtl/rhc_pkg.sv */
// shared types and constants for the rgb to hsv converter
package rhc_pkg;

  // channel and result widths
  localparam int unsigned CHAN_W = 8;
  localparam int unsigned QUO_W  = 16;
  // remainder width of the hue division, holds up to 6 * 255
  localparam int unsigned HREM_W = 11;

  // one division step per cell, so the chain has one cell per quotient bit
  localparam int unsigned NUM_CELLS = QUO_W;

  // work carried from cell to cell
  typedef struct packed {
    logic [CHAN_W-1:0] sat_rem;   // partial remainder of delta*65535 / max
    logic [CHAN_W-1:0] sat_div;   // max, forced to 1 for black
    logic [QUO_W-1:0]  sat_acc;   // low dividend bits shifting out, quotient bits in
    logic [HREM_W-1:0] hue_rem;   // partial remainder of num*65536 / (6*delta)
    logic [HREM_W-1:0] hue_div;   // 6*delta, forced to 1 for gray
    logic [QUO_W-1:0]  hue_quo;   // hue quotient bits
    logic [CHAN_W-1:0] bright;    // max channel byte
  } rhc_work_t;

endpackage

/* hw/rtl/rhc_front.sv */
// front end: max, min, delta, hue numerator and division operands
module rhc_front import rhc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CHAN_W-1:0] in_red,
  input  logic [CHAN_W-1:0] in_green,
  input  logic [CHAN_W-1:0] in_blue,
  output logic              out_valid,
  input  logic              out_ready,
  output rhc_work_t         out_work
);

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  localparam int unsigned NUM_W = HREM_W + 1;

  // first stage registers
  logic              s1_valid_r;
  logic              s1_valid_nxt;
  logic [CHAN_W-1:0] s1_red_r;
  logic [CHAN_W-1:0] s1_green_r;
  logic [CHAN_W-1:0] s1_blue_r;
  logic [CHAN_W-1:0] s1_max_r;
  logic [CHAN_W-1:0] s1_min_r;
  sector_t           s1_sec_r;
  logic              s1_ready;

  // second stage registers
  logic              s2_valid_r;
  logic              s2_valid_nxt;
  rhc_work_t         s2_work_r;
  rhc_work_t         s2_work_nxt;

  logic [CHAN_W-1:0] rg_max;
  logic [CHAN_W-1:0] rg_min;
  logic [CHAN_W-1:0] px_max;
  logic [CHAN_W-1:0] px_min;
  sector_t           px_sec;

  logic [CHAN_W-1:0] delta;
  logic [NUM_W-1:0]  d12;
  logic [NUM_W-1:0]  d6;
  logic [NUM_W-1:0]  base;
  logic [NUM_W-1:0]  diff;
  logic [NUM_W-1:0]  num;

  // ready chain: a stage takes an item when empty or when it drains
  assign s1_ready = !s2_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s1_ready;

  // max, min and sector, red wins ties over green, green over blue
  always_comb begin
    rg_max = (in_red >= in_green) ? in_red : in_green;
    rg_min = (in_red <= in_green) ? in_red : in_green;
    px_max = (rg_max >= in_blue) ? rg_max : in_blue;
    px_min = (rg_min <= in_blue) ? rg_min : in_blue;
    if (in_red >= in_green && in_red >= in_blue) begin
      px_sec = SEC_RED;
    end else if (in_green >= in_blue) begin
      px_sec = SEC_GREEN;
    end else begin
      px_sec = SEC_BLUE;
    end
  end

  // delta, hue numerator and division operands
  always_comb begin
    delta = s1_max_r - s1_min_r;
    d12   = {{(NUM_W-CHAN_W){1'b0}}, delta};
    d6    = (d12 << 2) + (d12 << 1);
    case (s1_sec_r)
      SEC_RED: begin
        base = (s1_green_r < s1_blue_r) ? d6 : '0;
        diff = {{(NUM_W-CHAN_W){1'b0}}, s1_green_r} - {{(NUM_W-CHAN_W){1'b0}}, s1_blue_r};
      end
      SEC_GREEN: begin
        base = d12 << 1;
        diff = {{(NUM_W-CHAN_W){1'b0}}, s1_blue_r} - {{(NUM_W-CHAN_W){1'b0}}, s1_red_r};
      end
      SEC_BLUE: begin
        base = d12 << 2;
        diff = {{(NUM_W-CHAN_W){1'b0}}, s1_red_r} - {{(NUM_W-CHAN_W){1'b0}}, s1_green_r};
      end
      default: begin
        base = '0;
        diff = '0;
      end
    endcase
    num = base + diff;

    // delta*65535 = (delta-1)*65536 + (65536-delta) for nonzero delta
    s2_work_nxt.sat_rem = (delta == '0) ? '0 : delta - CHAN_W'(1);
    s2_work_nxt.sat_acc = QUO_W'(0) - {{(QUO_W-CHAN_W){1'b0}}, delta};
    s2_work_nxt.sat_div = (s1_max_r == '0) ? CHAN_W'(1) : s1_max_r;
    s2_work_nxt.hue_rem = num[HREM_W-1:0];
    s2_work_nxt.hue_div = (delta == '0) ? HREM_W'(1) : d6[HREM_W-1:0];
    s2_work_nxt.hue_quo = '0;
    s2_work_nxt.bright  = s1_max_r;
  end

  // valid bits follow the ready chain
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s2_valid_nxt = s2_valid_r;
    if (in_ready) begin
      s1_valid_nxt = in_valid;
    end
    if (s1_ready) begin
      s2_valid_nxt = s1_valid_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_red_r   <= in_red;
      s1_green_r <= in_green;
      s1_blue_r  <= in_blue;
      s1_max_r   <= px_max;
      s1_min_r   <= px_min;
      s1_sec_r   <= px_sec;
    end
    if (s1_valid_r && s1_ready) begin
      s2_work_r <= s2_work_nxt;
    end
  end

  assign out_valid = s2_valid_r;
  assign out_work  = s2_work_r;

  // operands handed to the division chain are always legal
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r |-> (s2_work_r.sat_div != '0) && (s2_work_r.hue_div != '0))
    else $error("zero divisor entering division chain");

  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r |-> (s2_work_r.sat_rem < s2_work_r.sat_div)
                && (s2_work_r.hue_rem < s2_work_r.hue_div))
    else $error("initial remainder not below divisor");

  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> s1_min_r <= s1_max_r)
    else $error("min above max");

endmodule

/* hw/rtl/rhc_cell.sv */
// one restoring division step for saturation and hue, registered
module rhc_cell import rhc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  rhc_work_t in_work,
  output logic      out_valid,
  input  logic      out_ready,
  output rhc_work_t out_work
);

  logic               valid_r;
  logic               valid_nxt;
  rhc_work_t          work_r;
  rhc_work_t          work_nxt;

  logic [CHAN_W:0]    sat_trial;
  logic [CHAN_W:0]    sat_diff;
  logic               sat_ge;
  logic [HREM_W:0]    hue_trial;
  logic [HREM_W:0]    hue_diff;
  logic               hue_ge;

  assign in_ready = !valid_r || out_ready;

  // shift one bit into each remainder and subtract where it fits
  always_comb begin
    sat_trial = {in_work.sat_rem, in_work.sat_acc[QUO_W-1]};
    sat_diff  = sat_trial - {1'b0, in_work.sat_div};
    sat_ge    = sat_trial >= {1'b0, in_work.sat_div};
    hue_trial = {in_work.hue_rem, 1'b0};
    hue_diff  = hue_trial - {1'b0, in_work.hue_div};
    hue_ge    = hue_trial >= {1'b0, in_work.hue_div};

    work_nxt         = in_work;
    work_nxt.sat_rem = sat_ge ? sat_diff[CHAN_W-1:0] : sat_trial[CHAN_W-1:0];
    work_nxt.sat_acc = {in_work.sat_acc[QUO_W-2:0], sat_ge};
    work_nxt.hue_rem = hue_ge ? hue_diff[HREM_W-1:0] : hue_trial[HREM_W-1:0];
    work_nxt.hue_quo = {in_work.hue_quo[QUO_W-2:0], hue_ge};
  end

  // valid bit
  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      work_r <= work_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_work  = work_r;

  // remainders stay below their divisors
  a_sat_rem: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> work_r.sat_rem < work_r.sat_div)
    else $error("saturation remainder out of range");

  a_hue_rem: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> work_r.hue_rem < work_r.hue_div)
    else $error("hue remainder out of range");

  // a held item keeps its work while the next cell is busy
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !out_ready |=> valid_r && $stable(work_r))
    else $error("cell lost a stalled item");

endmodule

/* hw/rtl/rgb_to_hsv_converter.sv */
// rgb to hsv converter top level: front end and a chain of division cells
//
//   channel | dir | tdata fields (low bit first)
//   in_     | in  | red[7:0] green[15:8] blue[23:16]
//   out_    | out | hue[15:0] saturation[31:16] brightness[39:32]
//
// one item per clock sustained while out_tready is held high; two front-end stages,
// then one cell per quotient bit of the 16-bit saturation and hue divisions
// synchronous active-low reset empties every stage
// each stage holds its item when the next one is full, so bubbles close up
// and the last cell register is the output register
module rgb_to_hsv_converter import rhc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // red, green, blue
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // hue, saturation, brightness
);

  logic      chain_valid [NUM_CELLS+1];
  logic      chain_ready [NUM_CELLS+1];
  rhc_work_t chain_work  [NUM_CELLS+1];
  rhc_work_t last_work;

  // max, min, delta and operands
  rhc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_red    (in_tdata[7:0]),
    .in_green  (in_tdata[15:8]),
    .in_blue   (in_tdata[23:16]),
    .out_valid (chain_valid[0]),
    .out_ready (chain_ready[0]),
    .out_work  (chain_work[0])
  );

  // one quotient bit per cell
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    rhc_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (chain_valid[i]),
      .in_ready  (chain_ready[i]),
      .in_work   (chain_work[i]),
      .out_valid (chain_valid[i+1]),
      .out_ready (chain_ready[i+1]),
      .out_work  (chain_work[i+1])
    );
  end

  // result channel
  assign chain_ready[NUM_CELLS] = out_tready;
  assign last_work  = chain_work[NUM_CELLS];
  assign out_tvalid = chain_valid[NUM_CELLS];
  assign out_tdata  = {last_work.bright, last_work.sat_acc, last_work.hue_quo};

  // black pixels give zero hue and saturation
  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[39:32] == 8'd0 |-> out_tdata[31:0] == 32'd0)
    else $error("black pixel with nonzero hue or saturation");

endmodule

/* tb/sv/tb.sv */
// testbench for the rgb to hsv converter: directed and random pixels against a predictor
module tb import rhc_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_PIXELS = 850;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned MAX_PRINTED = 40;

  // one converted pixel, fields at the block's widths
  typedef struct packed {
    logic [QUO_W-1:0]  hue;
    logic [QUO_W-1:0]  sat;
    logic [CHAN_W-1:0] bright;
  } hsv_t;

  // one directed pixel; known rows carry a typed-in result
  typedef struct packed {
    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] b;
    logic              known;
    hsv_t              want;
  } pixel_case_t;

  localparam int unsigned NUM_DIRECTED = 21;

  localparam pixel_case_t DIRECTED_PIXELS [NUM_DIRECTED] = '{
    // black, white and grays
    '{8'd0,   8'd0,   8'd0,   1'b1, '{16'd0,     16'd0,     8'd0}},
    '{8'd255, 8'd255, 8'd255, 1'b1, '{16'd0,     16'd0,     8'd255}},
    '{8'd128, 8'd128, 8'd128, 1'b1, '{16'd0,     16'd0,     8'd128}},
    '{8'd1,   8'd1,   8'd1,   1'b1, '{16'd0,     16'd0,     8'd1}},
    // primaries and secondaries, ties resolved red over green over blue
    '{8'd255, 8'd0,   8'd0,   1'b1, '{16'd0,     16'd65535, 8'd255}},
    '{8'd0,   8'd255, 8'd0,   1'b1, '{16'd21845, 16'd65535, 8'd255}},
    '{8'd0,   8'd0,   8'd255, 1'b1, '{16'd43690, 16'd65535, 8'd255}},
    '{8'd255, 8'd255, 8'd0,   1'b1, '{16'd10922, 16'd65535, 8'd255}},
    '{8'd0,   8'd255, 8'd255, 1'b1, '{16'd32768, 16'd65535, 8'd255}},
    '{8'd255, 8'd0,   8'd255, 1'b1, '{16'd54613, 16'd65535, 8'd255}},
    // red sector wrapping just below a full turn
    '{8'd255, 8'd0,   8'd1,   1'b1, '{16'd65493, 16'd65535, 8'd255}},
    // smallest nonzero max and smallest spread at full scale
    '{8'd1,   8'd0,   8'd0,   1'b1, '{16'd0,     16'd65535, 8'd1}},
    '{8'd255, 8'd254, 8'd254, 1'b1, '{16'd0,     16'd257,   8'd255}},
    // assorted pixels left to the predictor
    '{8'h55,  8'hAA,  8'h33,  1'b0, '0},
    '{8'hAA,  8'h55,  8'hCC,  1'b0, '0},
    '{8'd200, 8'd100, 8'd50,  1'b0, '0},
    '{8'd10,  8'd200, 8'd199, 1'b0, '0},
    '{8'd0,   8'd200, 8'd200, 1'b0, '0},
    '{8'd128, 8'd127, 8'd129, 1'b0, '0},
    '{8'd254, 8'd255, 8'd253, 1'b0, '0},
    '{8'd1,   8'd2,   8'd0,   1'b0, '0}
  };

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // red, green, blue
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // hue, saturation, brightness

  hsv_t        pending_hsv [$];
  int unsigned n_errors = 0;
  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned n_cycles = 0;
  bit          tx_gaps = 1'b1;
  bit          rx_stalls = 1'b1;

  rgb_to_hsv_converter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // exact integer hsv of one pixel
  function automatic hsv_t hsv_of_pixel(input logic [CHAN_W-1:0] r, g, b);
    int unsigned rr, gg, bb, top, bottom, spread, num;
    hsv_t res;
    rr = 32'(r);
    gg = 32'(g);
    bb = 32'(b);
    top = rr;
    if (gg > top) top = gg;
    if (bb > top) top = bb;
    bottom = rr;
    if (gg < bottom) bottom = gg;
    if (bb < bottom) bottom = bb;
    spread = top - bottom;
    res.bright = CHAN_W'(top);
    res.sat = (top == 0) ? '0 : QUO_W'((spread * 32'd65535) / top);
    res.hue = '0;
    if (spread != 0) begin
      // sector offset in units of spread, kept nonnegative
      if (rr == top) begin
        num = (gg >= bb) ? gg - bb : 6 * spread - (bb - gg);
      end else if (gg == top) begin
        num = 2 * spread + bb - rr;
      end else begin
        num = 4 * spread + rr - gg;
      end
      res.hue = QUO_W'((num * 32'd65536) / (6 * spread));
    end
    return res;
  endfunction

  // print one mismatch line and count it
  task automatic report_mismatch(input string msg);
    if (n_errors < MAX_PRINTED) $display("MISMATCH @%0t: %s", $realtime, msg);
    n_errors++;
  endtask

  // hand one pixel over and queue its result once accepted
  task automatic send_pixel(input logic [CHAN_W-1:0] r, g, b, input hsv_t want);
    in_tvalid <= 1'b1;
    in_tdata  <= {b, g, r};
    do @(posedge clk); while (!in_tready);
    pending_hsv.push_back(want);
    n_sent++;
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // stimulus
  initial begin
    logic [CHAN_W-1:0] r, g, b, lvl;
    int unsigned       kind;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed pixels
    foreach (DIRECTED_PIXELS[i]) begin
      send_pixel(DIRECTED_PIXELS[i].r, DIRECTED_PIXELS[i].g, DIRECTED_PIXELS[i].b,
                 DIRECTED_PIXELS[i].known ? DIRECTED_PIXELS[i].want :
                 hsv_of_pixel(DIRECTED_PIXELS[i].r, DIRECTED_PIXELS[i].g,
                              DIRECTED_PIXELS[i].b));
    end

    // random pixels, biased toward grays, ties, dark and saturated ones
    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      tx_gaps   = (i < 300) || (i >= 450 && i < 700);
      rx_stalls = tx_gaps;
      if (i == 450) begin
        // hold off until the pipeline has emptied
        in_tvalid <= 1'b0;
        while (pending_hsv.size() != 0) @(posedge clk);
      end
      kind = $urandom_range(0, 9);
      r = 8'($urandom_range(0, 255));
      g = 8'($urandom_range(0, 255));
      b = 8'($urandom_range(0, 255));
      case (kind)
        0: begin
          g = r;
          b = r;
        end
        1: begin
          lvl = 8'($urandom_range(0, 255));
          case ($urandom_range(0, 2))
            0: begin r = lvl; g = lvl; if (b > lvl) b = lvl; end
            1: begin g = lvl; b = lvl; if (r > lvl) r = lvl; end
            default: begin r = lvl; b = lvl; if (g > lvl) g = lvl; end
          endcase
        end
        2: begin
          r = 8'($urandom_range(0, 7));
          g = 8'($urandom_range(0, 7));
          b = 8'($urandom_range(0, 7));
        end
        3: begin
          case ($urandom_range(0, 2))
            0: r = 8'd255;
            1: g = 8'd255;
            default: b = 8'd255;
          endcase
        end
        default: ;
      endcase
      send_pixel(r, g, b, hsv_of_pixel(r, g, b));
    end
    in_tvalid <= 1'b0;

    // wait out the pipeline, then idle for DRAIN_CYCLES to catch stray items
    while (pending_hsv.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d pixels (%0d directed), checked %0d results", n_sent,
             NUM_DIRECTED, n_checked);
    $display("covered black, gray, primaries, ties, red wrap and random pixels under stalls");
    if (n_errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // result side stalls
  initial begin
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (rx_stalls && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // compare each result item with the oldest expectation
  always @(posedge clk) begin : check_results
    hsv_t want;
    hsv_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.hue    = out_tdata[15:0];
      got.sat    = out_tdata[31:16];
      got.bright = out_tdata[39:32];
      if (pending_hsv.size() == 0) begin
        report_mismatch($sformatf("unexpected result hue %0d sat %0d bright %0d",
                                  got.hue, got.sat, got.bright));
      end else begin
        want = pending_hsv.pop_front();
        n_checked++;
        if (got.hue !== want.hue)
          report_mismatch($sformatf("result %0d hue %0d, want %0d", n_checked,
                                    got.hue, want.hue));
        if (got.sat !== want.sat)
          report_mismatch($sformatf("result %0d saturation %0d, want %0d", n_checked,
                                    got.sat, want.sat));
        if (got.bright !== want.bright)
          report_mismatch($sformatf("result %0d brightness %0d, want %0d", n_checked,
                                    got.bright, want.bright));
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", n_cycles,
               pending_hsv.size());
      $display("tb NOT OK");
      $finish;
    end
  end

endmodule

/* sim.f */
hw/rtl/rhc_pkg.sv
hw/rtl/rhc_front.sv
hw/rtl/rhc_cell.sv
hw/rtl/rgb_to_hsv_converter.sv
tb/sv/tb.sv
